// ===== rtl/iaw_pkg.sv =====
// iaw_pkg: shared widths, register indexes and q16.16 helpers for the
// two-axis integral block with back-calculation anti-windup
// no dependencies
package iaw_pkg;

    // q16.16 fixed point
    localparam int DATA_W  = 32;
    localparam int QFRAC   = 16;
    localparam int OPA_W   = 33;
    localparam int OPB_W   = 32;
    localparam int PROD_W  = OPA_W + OPB_W - 1 + 1;
    localparam int QP_W    = PROD_W - QFRAC;
    localparam int SUM_W   = QP_W + 2;
    localparam int UCFG_W  = 31;

    // configuration register indexes
    localparam logic [2:0] REG_PP_GAIN  = 3'd0;
    localparam logic [2:0] REG_PY_GAIN  = 3'd1;
    localparam logic [2:0] REG_YP_GAIN  = 3'd2;
    localparam logic [2:0] REG_YY_GAIN  = 3'd3;
    localparam logic [2:0] REG_P_RECIP  = 3'd4;
    localparam logic [2:0] REG_Y_RECIP  = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;
    localparam logic [2:0] REG_PERIOD   = 3'd7;

    // reset values
    localparam logic [UCFG_W-1:0] RECIP_RST  = 31'd65536;
    localparam logic [UCFG_W-1:0] LIMIT_RST  = 31'd655360;
    localparam logic [UCFG_W-1:0] PERIOD_RST = 31'd66;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [QP_W-1:0]   t_qprod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [DATA_W-1:0] t_q16;

    // drop the fraction of a product, rounding toward zero
    function automatic t_qprod f_qtrunc(input t_prod p);
        t_prod t;
        t = p + (p[PROD_W-1] ? t_prod'((1 << QFRAC) - 1) : t_prod'(0));
        return t[PROD_W-1:QFRAC];
    endfunction

    // saturate a wide sum to the signed 32-bit range
    function automatic t_q16 f_sat32(input t_sum x);
        logic hi_same;
        hi_same = (&x[SUM_W-1:DATA_W-1]) | ~(|x[SUM_W-1:DATA_W-1]);
        if (hi_same) begin
            return x[DATA_W-1:0];
        end else if (x[SUM_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/integral_antiwindup_two_axis.sv =====
// integral action with back-calculation anti-windup for pitch and yaw axes
// one shared 33x32 signed multiplier under a small sequencer; uses iaw_pkg
// steps: mul_y, rate, mul_t, integ, clamp, mul_c, corr; a new item is taken only
// after corr has loaded the output; the multiplier is used four times per item,
// every step ends in a register, and a stalled output beat holds the last step
// reset (synchronous, active low): both integrators and corrections to zero,
// gains zero, 1/tr 1.0, limit 10.0, sample period 66/65536
module integral_antiwindup_two_axis
    import iaw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_func,
    input  logic signed [DATA_W-1:0] i_pitch_error,
    input  logic signed [DATA_W-1:0] i_yaw_error,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_integral_drive
);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_Y = 3'd1;
    localparam logic [2:0] S_RATE  = 3'd2;
    localparam logic [2:0] S_MUL_T = 3'd3;
    localparam logic [2:0] S_INTEG = 3'd4;
    localparam logic [2:0] S_CLAMP = 3'd5;
    localparam logic [2:0] S_MUL_C = 3'd6;
    localparam logic [2:0] S_CORR  = 3'd7;

    // configuration registers
    logic signed [DATA_W-1:0] r_gain_pp, r_gain_py, r_gain_yp, r_gain_yy;
    logic [UCFG_W-1:0]        r_recip_p, r_recip_y, r_limit, r_period;

    // axis state
    t_q16 r_integ [2];
    t_q16 r_corr  [2];

    // sequencer and working registers
    logic [2:0]              r_state, n_state;
    logic                    r_ax;
    t_q16                    r_ye;
    t_prod                   r_prod;
    logic signed [SUM_W-2:0] r_acc;
    t_q16                    r_rate;
    t_q16                    r_drive;
    logic signed [OPA_W-1:0] r_diff;
    logic                    r_out_valid;
    t_q16                    r_out;

    logic                    w_cfg_wr;
    logic                    w_in_acc;
    logic                    w_out_load;
    logic                    w_prod_en;
    logic signed [OPA_W-1:0] w_mul_a;
    logic signed [OPB_W-1:0] w_mul_b;
    t_prod                   w_prod;
    t_qprod                  w_qp;
    logic signed [SUM_W-2:0] n_acc;
    t_q16                    n_rate;
    t_q16                    n_integ;
    t_q16                    n_corr;
    logic signed [OPA_W-1:0] w_lim;
    logic signed [OPA_W-1:0] w_integ_x;
    logic signed [OPA_W-1:0] n_drive;
    logic signed [OPA_W-1:0] n_diff;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel & penable & pwrite & pready;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid & ~o_in_stall;
    assign w_out_load  = (r_state == S_CORR) & (~r_out_valid | ~i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_integral_drive = r_out;

    // register read back
    always_comb begin
        case (paddr[4:2])
            REG_PP_GAIN: prdata = r_gain_pp;
            REG_PY_GAIN: prdata = r_gain_py;
            REG_YP_GAIN: prdata = r_gain_yp;
            REG_YY_GAIN: prdata = r_gain_yy;
            REG_P_RECIP: prdata = {1'b0, r_recip_p};
            REG_Y_RECIP: prdata = {1'b0, r_recip_y};
            REG_LIMIT:   prdata = {1'b0, r_limit};
            REG_PERIOD:  prdata = {1'b0, r_period};
            default:     prdata = '0;
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_pp <= '0;
            r_gain_py <= '0;
            r_gain_yp <= '0;
            r_gain_yy <= '0;
            r_recip_p <= RECIP_RST;
            r_recip_y <= RECIP_RST;
            r_limit   <= LIMIT_RST;
            r_period  <= PERIOD_RST;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_PP_GAIN: r_gain_pp <= pwdata;
                REG_PY_GAIN: r_gain_py <= pwdata;
                REG_YP_GAIN: r_gain_yp <= pwdata;
                REG_YY_GAIN: r_gain_yy <= pwdata;
                REG_P_RECIP: r_recip_p <= pwdata[UCFG_W-1:0];
                REG_Y_RECIP: r_recip_y <= pwdata[UCFG_W-1:0];
                REG_LIMIT:   r_limit   <= pwdata[UCFG_W-1:0];
                REG_PERIOD:  r_period  <= pwdata[UCFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_prod_en = 1'b0;
        w_mul_a   = '0;
        w_mul_b   = '0;
        case (r_state)
            S_IDLE: begin
                w_prod_en = w_in_acc;
                w_mul_a   = OPA_W'(i_pitch_error);
                w_mul_b   = i_func ? r_gain_yp : r_gain_pp;
            end
            S_MUL_Y: begin
                w_prod_en = 1'b1;
                w_mul_a   = OPA_W'(r_ye);
                w_mul_b   = r_ax ? r_gain_yy : r_gain_py;
            end
            S_MUL_T: begin
                w_prod_en = 1'b1;
                w_mul_a   = OPA_W'(r_rate);
                w_mul_b   = {1'b0, r_period};
            end
            S_MUL_C: begin
                w_prod_en = 1'b1;
                w_mul_a   = r_diff;
                w_mul_b   = {1'b0, (r_ax ? r_recip_y : r_recip_p)};
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_qp   = f_qtrunc(r_prod);

    // datapath next values
    always_comb begin
        n_acc     = (SUM_W-1)'(w_qp) + (SUM_W-1)'(r_corr[r_ax]);
        n_rate    = f_sat32(t_sum'(r_acc) + t_sum'(w_qp));
        n_integ   = f_sat32(t_sum'(r_integ[r_ax]) + t_sum'(w_qp));
        n_corr    = f_sat32(t_sum'(w_qp));
        w_lim     = {2'b00, r_limit};
        w_integ_x = OPA_W'(r_integ[r_ax]);
        if (w_integ_x < -w_lim) begin
            n_drive = -w_lim;
        end else if (w_integ_x > w_lim) begin
            n_drive = w_lim;
        end else begin
            n_drive = w_integ_x;
        end
        n_diff = n_drive - w_integ_x;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_RATE;
            S_RATE:  n_state = S_MUL_T;
            S_MUL_T: n_state = S_INTEG;
            S_INTEG: n_state = S_CLAMP;
            S_CLAMP: n_state = S_MUL_C;
            S_MUL_C: n_state = S_CORR;
            S_CORR:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ[0]  <= '0;
            r_integ[1]  <= '0;
            r_corr[0]   <= '0;
            r_corr[1]   <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_INTEG) begin
                r_integ[r_ax] <= n_integ;
            end
            if (w_out_load) begin
                r_corr[r_ax] <= n_corr;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ax <= i_func;
            r_ye <= i_yaw_error;
        end
        if (w_prod_en) begin
            r_prod <= w_prod;
        end
        if (r_state == S_MUL_Y) begin
            r_acc <= n_acc;
        end
        if (r_state == S_RATE) begin
            r_rate <= n_rate;
        end
        if (r_state == S_CLAMP) begin
            r_drive <= n_drive[DATA_W-1:0];
            r_diff  <= n_diff;
        end
        if (w_out_load) begin
            r_out <= r_drive;
        end
    end

endmodule
